/* design/srhex_pkg.sv */
// Shared types, constants and helpers of the S-record text encoder.
`default_nettype none

package srhex_pkg;

    // Record buffer geometry and counter widths.
    localparam int BUF_DEPTH            = 16;
    localparam int BUF_AW               = 4;
    localparam int FILL_W               = 5;
    localparam int POS_W                = 6;
    localparam int CHAR_W               = 7;
    localparam int DEF_BYTES_PER_RECORD = 16;

    // ASCII codes used by the record framing.
    localparam logic [CHAR_W-1:0] ASC_S       = 7'h53;
    localparam logic [CHAR_W-1:0] ASC_0       = 7'h30;
    localparam logic [CHAR_W-1:0] ASC_1       = 7'h31;
    localparam logic [CHAR_W-1:0] ASC_5       = 7'h35;
    localparam logic [CHAR_W-1:0] ASC_9       = 7'h39;
    localparam logic [CHAR_W-1:0] ASC_A       = 7'h41;
    localparam logic [CHAR_W-1:0] ASC_NEWLINE = 7'h0A;

    // Fixed bytes of every record: count field overhead and checksum mask.
    localparam logic [7:0] COUNT_OVERHEAD = 8'h03;
    localparam logic [7:0] BYTE_MASK      = 8'hFF;

    typedef enum logic [1:0] {
        REC_S0 = 2'd0,
        REC_S1 = 2'd1,
        REC_S5 = 2'd2,
        REC_S9 = 2'd3
    } rec_kind_t;

    typedef struct packed {
        logic      load;       // input transfer this cycle
        logic      emit;       // load one character into the output register
        logic      last;       // that character ends the item's output
        rec_kind_t kind;       // record being written
        logic      rec_done;   // S1 record finished: advance address and total
        logic      clear_all;  // stream finished: back to the reset state
    } ctrl_cmd_t;

    typedef struct packed {
        logic hdr_done;
        logic action;          // action of the item being worked on
        logic full_next;       // one more byte completes a record
        logic full;            // buffer holds a complete record
        logic fill_nz;         // buffer holds at least one byte
        logic at_newline;      // current position is the record's newline
        logic out_free;        // output register can take a character
    } ctrl_status_t;

    function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
        logic [CHAR_W-1:0] res;
        if (nib < 4'd10) begin
            res = ASC_0 + {3'b000, nib};
        end else begin
            res = ASC_A + {3'b000, nib} - 7'd10;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* design/srhex_ctrl.sv */
// Controller state machine that sequences the records of each item.
`default_nettype none

module srhex_ctrl (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    input  wire logic                    s_action,
    output logic                         s_ready,
    input  wire srhex_pkg::ctrl_status_t status,
    output srhex_pkg::ctrl_cmd_t         cmd
);
    import srhex_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_HDR  = 5'b00010,
        ST_REC1 = 5'b00100,
        ST_REC5 = 5'b01000,
        ST_REC9 = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   rec_end;

    assign s_ready = (state_reg == ST_IDLE);
    assign rec_end = status.out_free && status.at_newline;

    always_comb begin
        state_next    = state_reg;
        cmd.load      = 1'b0;
        cmd.emit      = 1'b0;
        cmd.last      = 1'b0;
        cmd.kind      = REC_S0;
        cmd.rec_done  = 1'b0;
        cmd.clear_all = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (!status.hdr_done) begin
                        state_next = ST_HDR;
                    end else if (!s_action) begin
                        state_next = status.full_next ? ST_REC1 : ST_IDLE;
                    end else begin
                        state_next = status.fill_nz ? ST_REC1 : ST_REC5;
                    end
                end
            end
            ST_HDR: begin
                cmd.kind = REC_S0;
                cmd.emit = status.out_free;
                if (rec_end) begin
                    if (!status.action) begin
                        state_next = status.full ? ST_REC1 : ST_IDLE;
                        cmd.last   = !status.full;
                    end else begin
                        state_next = status.fill_nz ? ST_REC1 : ST_REC5;
                    end
                end
            end
            ST_REC1: begin
                cmd.kind = REC_S1;
                cmd.emit = status.out_free;
                if (rec_end) begin
                    cmd.rec_done = 1'b1;
                    cmd.last     = !status.action;
                    state_next   = status.action ? ST_REC5 : ST_IDLE;
                end
            end
            ST_REC5: begin
                cmd.kind = REC_S5;
                cmd.emit = status.out_free;
                if (rec_end) begin
                    state_next = ST_REC9;
                end
            end
            ST_REC9: begin
                cmd.kind = REC_S9;
                cmd.emit = status.out_free;
                if (rec_end) begin
                    cmd.last      = 1'b1;
                    cmd.clear_all = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // The header flag is set at the transfer that starts output, so every
    // record state runs with it set.
    a_busy_has_header: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> status.hdr_done)
        else $error("record in progress without header flag");

    // A data record is only written while the buffer holds bytes.
    a_rec1_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_REC1) |-> status.fill_nz)
        else $error("S1 record with empty buffer");

    // Leaving a record state to idle always marks the item's final character.
    a_last_on_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE && state_next == ST_IDLE) |-> cmd.last)
        else $error("item output ended without last flag");

endmodule

`default_nettype wire

/* design/srhex_dpath.sv */
// Datapath: record buffer, stream counters, character generator and output register.
`default_nettype none

module srhex_dpath #(
    parameter int BYTES_PER_RECORD = srhex_pkg::DEF_BYTES_PER_RECORD
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire srhex_pkg::ctrl_cmd_t        cmd,
    output srhex_pkg::ctrl_status_t          status,
    input  wire logic                        s_action,
    input  wire logic [7:0]                  s_data_byte,
    input  wire logic                        m_ready,
    output logic                             m_valid,
    output logic [srhex_pkg::CHAR_W-1:0]     m_char_code,
    output logic                             m_last_of_run
);
    import srhex_pkg::*;

    localparam logic [FILL_W:0] BPR_L = (FILL_W+1)'(BYTES_PER_RECORD);

    logic [7:0]        buf_mem [BUF_DEPTH];
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [15:0]       addr_reg, addr_next;
    logic [15:0]       total_reg, total_next;
    logic              hdr_reg, hdr_next;
    logic [7:0]        sum_reg, sum_next;
    logic              action_reg;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              m_valid_reg;
    logic [CHAR_W-1:0] m_char_reg;
    logic              m_last_reg;
    logic [7:0]        buf_rd_reg;

    // Per-record view of the fields.
    logic [FILL_W-1:0] rec_n;
    logic [15:0]       rec_addr;
    logic [7:0]        rec_sum;
    logic [CHAR_W-1:0] type_char;
    logic [7:0]        cnt_byte;
    logic [7:0]        chk_byte;
    logic [POS_W-1:0]  nl_pos;
    logic [POS_W-1:0]  pos_m2;
    logic [POS_W-1:0]  pos_nm2;
    logic [FILL_W-1:0] byte_idx;
    logic [FILL_W-1:0] rd_idx_next;
    logic [7:0]        cur_byte;
    logic [3:0]        cur_nib;
    logic [CHAR_W-1:0] cur_char;
    logic              at_nl;
    logic              out_free;

    always_comb begin
        rec_n     = '0;
        rec_addr  = '0;
        rec_sum   = '0;
        type_char = ASC_0;
        case (cmd.kind)
            REC_S0: begin
                type_char = ASC_0;
            end
            REC_S1: begin
                type_char = ASC_1;
                rec_n     = fill_reg;
                rec_addr  = addr_reg;
                rec_sum   = sum_reg;
            end
            REC_S5: begin
                type_char = ASC_5;
                rec_addr  = total_reg;
            end
            REC_S9: begin
                type_char = ASC_9;
            end
            default: begin
                type_char = ASC_0;
            end
        endcase
    end

    // Character layout: 'S', type digit, count, address, data, checksum as hex
    // pairs, then a newline. The count byte is the data length plus three.
    assign cnt_byte = {3'b000, rec_n} + COUNT_OVERHEAD;
    assign chk_byte = (cnt_byte + rec_addr[15:8] + rec_addr[7:0] + rec_sum) ^ BYTE_MASK;
    assign nl_pos   = {rec_n, 1'b0} + POS_W'(10);
    assign at_nl    = (pos_reg == nl_pos);
    assign pos_m2   = pos_reg - POS_W'(2);
    assign byte_idx = pos_m2[POS_W-1:1];

    // The buffer is read into a register from the next character position, so
    // the registered byte always belongs to the current position.
    assign pos_nm2     = pos_next - POS_W'(2);
    assign rd_idx_next = pos_nm2[POS_W-1:1] - FILL_W'(3);

    always_comb begin
        if (byte_idx == FILL_W'(0)) begin
            cur_byte = cnt_byte;
        end else if (byte_idx == FILL_W'(1)) begin
            cur_byte = rec_addr[15:8];
        end else if (byte_idx == FILL_W'(2)) begin
            cur_byte = rec_addr[7:0];
        end else if (byte_idx == rec_n + FILL_W'(3)) begin
            cur_byte = chk_byte;
        end else begin
            cur_byte = buf_rd_reg;
        end
    end

    assign cur_nib = pos_m2[0] ? cur_byte[3:0] : cur_byte[7:4];

    always_comb begin
        if (pos_reg == POS_W'(0)) begin
            cur_char = ASC_S;
        end else if (pos_reg == POS_W'(1)) begin
            cur_char = type_char;
        end else if (at_nl) begin
            cur_char = ASC_NEWLINE;
        end else begin
            cur_char = hex_char(cur_nib);
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        fill_next  = fill_reg;
        addr_next  = addr_reg;
        total_next = total_reg;
        hdr_next   = hdr_reg;
        sum_next   = sum_reg;
        pos_next   = pos_reg;
        if (cmd.load) begin
            hdr_next = 1'b1;
            if (!s_action) begin
                fill_next = fill_reg + FILL_W'(1);
                sum_next  = sum_reg + s_data_byte;
            end
        end
        if (cmd.emit) begin
            pos_next = at_nl ? '0 : pos_reg + POS_W'(1);
        end
        if (cmd.rec_done) begin
            addr_next  = addr_reg + {11'd0, fill_reg};
            total_next = total_reg + 16'd1;
            fill_next  = '0;
            sum_next   = '0;
        end
        if (cmd.clear_all) begin
            fill_next  = '0;
            addr_next  = '0;
            total_next = '0;
            hdr_next   = 1'b0;
            sum_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= '0;
            addr_reg    <= '0;
            total_reg   <= '0;
            hdr_reg     <= 1'b0;
            sum_reg     <= '0;
            pos_reg     <= '0;
            action_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            fill_reg   <= fill_next;
            addr_reg   <= addr_next;
            total_reg  <= total_next;
            hdr_reg    <= hdr_next;
            sum_reg    <= sum_next;
            pos_reg    <= pos_next;
            if (cmd.load) begin
                action_reg <= s_action;
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load && !s_action) begin
            buf_mem[fill_reg[BUF_AW-1:0]] <= s_data_byte;
        end
        buf_rd_reg <= buf_mem[rd_idx_next[BUF_AW-1:0]];
        if (cmd.emit) begin
            m_char_reg <= cur_char;
            m_last_reg <= cmd.last;
        end
    end

    assign status.hdr_done   = hdr_reg;
    assign status.action     = action_reg;
    assign status.full_next  = ({1'b0, fill_reg} + (FILL_W+1)'(1)) >= BPR_L;
    assign status.full       = {1'b0, fill_reg} >= BPR_L;
    assign status.fill_nz    = (fill_reg != '0);
    assign status.at_newline = at_nl;
    assign status.out_free   = out_free;

    assign m_valid       = m_valid_reg;
    assign m_char_code   = m_char_reg;
    assign m_last_of_run = m_last_reg;

    // The buffer never holds more than one record's worth of bytes.
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, fill_reg} <= BPR_L)
        else $error("record buffer overfilled");

    // The character position never runs past the record's newline while a
    // data record is being written.
    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && cmd.kind == REC_S1) |-> (pos_reg <= nl_pos))
        else $error("character position beyond newline");

    // A character loaded while the receiver stalls is never overwritten.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !cmd.emit)
        else $error("output register overwritten during stall");

endmodule

`default_nettype wire

/* design/srecord_hex_encoder_core.sv */
// Top level of the S-record (S19) text encoder: controller plus datapath.
//
// Input channel (s_valid/s_ready, s_action, s_data_byte): s_action 0 carries
// one raw byte, s_action 1 ends the stream. Output channel (m_valid/m_ready,
// m_char_code, m_last_of_run): one ASCII character per transfer, with
// m_last_of_run set on the final character caused by an input item.
// The first item after reset produces the S0 header. Each full record of
// BYTES_PER_RECORD bytes is written as an S1 line of 2n+11 characters; an end
// item flushes a partial S1 line, writes S5 and S9 (11 characters each) and
// returns the block to its reset state. Apart from the header, a byte that
// completes no record produces no characters and leaves the block ready.
// After an item's transfer the first character is loaded into the output
// register once it is free; characters then follow one per cycle, set by the
// single output register, while the receiver keeps m_ready high. A new item
// is taken only once the previous item's last character sits in the output
// register, which may still be waiting for the receiver.
// When a character waits and m_ready is low, the output register holds and
// character generation pauses. Reset (aresetn low, synchronous) clears all
// counters, the header flag and the output valid.
`default_nettype none

module srecord_hex_encoder_core #(
    parameter int BYTES_PER_RECORD = srhex_pkg::DEF_BYTES_PER_RECORD
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic                        s_action,
    input  wire logic [7:0]                  s_data_byte,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [srhex_pkg::CHAR_W-1:0]     m_char_code,
    output logic                             m_last_of_run
);
    import srhex_pkg::*;

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    srhex_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_action (s_action),
        .s_ready  (s_ready),
        .status   (status),
        .cmd      (cmd)
    );

    srhex_dpath #(
        .BYTES_PER_RECORD (BYTES_PER_RECORD)
    ) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .s_action      (s_action),
        .s_data_byte   (s_data_byte),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_char_code   (m_char_code),
        .m_last_of_run (m_last_of_run)
    );

endmodule

`default_nettype wire

/* verif/tb.sv */
// Self-checking testbench for the S-record text encoder core.
`timescale 1ns / 1ps

module tb;
    import srhex_pkg::*;

    localparam bit ACT_DATA      = 1'b0;
    localparam bit ACT_END       = 1'b1;
    localparam int BYTES_PER_REC = DEF_BYTES_PER_RECORD;
    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 60;

    typedef struct packed {
        logic       act;
        logic [7:0] data;
    } enc_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } text_char_t;

    logic              aclk          = 1'b0;
    logic              aresetn       = 1'b0;
    logic              s_valid       = 1'b0;
    logic              s_ready;
    logic              s_action      = 1'b0;
    logic [7:0]        s_data_byte   = 8'h00;
    logic              m_valid;
    logic              m_ready       = 1'b0;
    logic [CHAR_W-1:0] m_char_code;
    logic              m_last_of_run;

    // Items waiting for the driver, and the text the encoder still owes us.
    enc_item_t         input_items[$];
    text_char_t        exp_chars[$];
    logic [CHAR_W-1:0] item_text[$];

    // Predicted encoder state.
    logic [7:0]  rec_bytes [BYTES_PER_REC];
    logic [4:0]  fill_cnt  = '0;
    logic [15:0] load_addr = '0;
    logic [15:0] rec_count = '0;
    logic        hdr_sent  = 1'b0;
    logic [7:0]  byte_sum  = '0;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned err_count      = 0;
    int unsigned quiet_cycles   = 0;
    enc_item_t   next_item;
    text_char_t  got_char;
    text_char_t  want_char;

    srecord_hex_encoder_core u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_data_byte   (s_data_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_char_code   (m_char_code),
        .m_last_of_run (m_last_of_run)
    );

    always #6 aclk = ~aclk;

    function automatic logic [CHAR_W-1:0] nibble_ascii(input logic [3:0] n);
        return (n > 4'd9) ? ASC_A + CHAR_W'(n - 4'd10) : ASC_0 + CHAR_W'(n);
    endfunction

    task automatic push_char(input logic [CHAR_W-1:0] c);
        item_text.push_back(c);
    endtask

    task automatic push_hex(input logic [7:0] v);
        push_char(nibble_ascii(v[7:4]));
        push_char(nibble_ascii(v[3:0]));
    endtask

    // S0 and S9 share one shape: count 03, address 0000 and checksum FC.
    task automatic put_fixed_record(input logic [CHAR_W-1:0] kind);
        logic [7:0] cs;
        cs = ~COUNT_OVERHEAD;
        push_char(ASC_S);
        push_char(kind);
        push_hex(COUNT_OVERHEAD);
        push_hex(8'h00);
        push_hex(8'h00);
        push_hex(cs);
        push_char(ASC_NEWLINE);
    endtask

    task automatic put_data_record();
        logic [7:0] cnt;
        logic [7:0] cs;
        cnt = 8'(fill_cnt) + COUNT_OVERHEAD;
        cs  = ~(cnt + load_addr[15:8] + load_addr[7:0] + byte_sum);
        push_char(ASC_S);
        push_char(ASC_1);
        push_hex(cnt);
        push_hex(load_addr[15:8]);
        push_hex(load_addr[7:0]);
        for (int i = 0; i < int'(fill_cnt); i++) begin
            push_hex(rec_bytes[i]);
        end
        push_hex(cs);
        push_char(ASC_NEWLINE);
        load_addr = load_addr + 16'(fill_cnt);
        rec_count = rec_count + 16'd1;
        fill_cnt  = '0;
        byte_sum  = '0;
    endtask

    // Works out the characters one item causes and queues them in order.
    task automatic encode_item(input logic act, input logic [7:0] b);
        logic [7:0] cs;
        text_char_t ch;
        item_text.delete();
        if (!hdr_sent) begin
            put_fixed_record(ASC_0);
            hdr_sent = 1'b1;
        end
        if (act == ACT_DATA) begin
            rec_bytes[fill_cnt[3:0]] = b;
            fill_cnt = fill_cnt + 5'd1;
            byte_sum = byte_sum + b;
            if (fill_cnt >= BYTES_PER_REC) begin
                put_data_record();
            end
        end else begin
            if (fill_cnt != 0) begin
                put_data_record();
            end
            cs = ~(COUNT_OVERHEAD + rec_count[15:8] + rec_count[7:0]);
            push_char(ASC_S);
            push_char(ASC_5);
            push_hex(COUNT_OVERHEAD);
            push_hex(rec_count[15:8]);
            push_hex(rec_count[7:0]);
            push_hex(cs);
            push_char(ASC_NEWLINE);
            put_fixed_record(ASC_9);
            fill_cnt  = '0;
            load_addr = '0;
            rec_count = '0;
            hdr_sent  = 1'b0;
            byte_sum  = '0;
        end
        for (int i = 0; i < item_text.size(); i++) begin
            ch.code = item_text[i];
            ch.last = (i == item_text.size() - 1);
            exp_chars.push_back(ch);
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on %s: got 0x%0h, expected 0x%0h", what, got, want);
        err_count++;
    endtask

    task automatic push_item(input logic act, input logic [7:0] b);
        enc_item_t it;
        it.act  = act;
        it.data = b;
        input_items.push_back(it);
    endtask

    task automatic push_random_byte();
        int unsigned r;
        r = $urandom_range(9);
        if (r == 0) begin
            push_item(ACT_DATA, 8'h00);
        end else if (r == 1) begin
            push_item(ACT_DATA, 8'hFF);
        end else begin
            push_item(ACT_DATA, 8'($urandom_range(255)));
        end
    endtask

    // Mostly whole streams ending in an end item; now and then a stream is
    // left open so the next one continues the same file.
    task automatic push_random_streams(input int unsigned n_items);
        int unsigned target;
        int unsigned len;
        int unsigned r;
        target = input_items.size() + n_items;
        while (input_items.size() < target) begin
            r = $urandom_range(9);
            if (r < 5) begin
                len = $urandom_range(15);
            end else if (r < 7) begin
                len = 16 * $urandom_range(1, 2);
            end else begin
                len = $urandom_range(17, 40);
            end
            repeat (len) push_random_byte();
            if ($urandom_range(7) != 0) begin
                push_item(ACT_END, 8'($urandom_range(255)));
            end
        end
    endtask

    task automatic wait_drained();
        do begin
            @(negedge aclk);
        end while (input_items.size() != 0 || s_valid || exp_chars.size() != 0);
    endtask

    // Driver: predicts an item's text when it is put on the bus, since a
    // presented item is held until its transfer.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (input_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_item = input_items.pop_front();
                encode_item(next_item.act, next_item.data);
                s_valid     <= 1'b1;
                s_action    <= next_item.act;
                s_data_byte <= next_item.data;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each character transfer and stalls the output at random.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got_char.code = m_char_code;
                got_char.last = m_last_of_run;
                if (exp_chars.size() == 0) begin
                    report_mismatch("unexpected character", int'(got_char.code), 0);
                end else begin
                    want_char = exp_chars.pop_front();
                    if (got_char.code !== want_char.code) begin
                        report_mismatch("char_code", int'(got_char.code),
                                        int'(want_char.code));
                    end
                    if (got_char.last !== want_char.last) begin
                        report_mismatch("last_of_run", int'(got_char.last),
                                        int'(want_char.last));
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // End as the very first item, with a nonzero byte that must be ignored.
        push_item(ACT_END, 8'hFF);
        // One full record with the byte extremes, then an end on an empty buffer.
        push_item(ACT_DATA, 8'h00);
        push_item(ACT_DATA, 8'hFF);
        push_item(ACT_DATA, 8'h01);
        push_item(ACT_DATA, 8'h80);
        push_item(ACT_DATA, 8'h7F);
        push_item(ACT_DATA, 8'hFE);
        push_item(ACT_DATA, 8'h55);
        push_item(ACT_DATA, 8'hAA);
        repeat (8) push_random_byte();
        push_item(ACT_END, 8'h00);
        // A short record flushed by the end item.
        repeat (3) push_item(ACT_DATA, 8'hFF);
        push_item(ACT_END, 8'hAA);
        wait_drained();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        push_random_streams(50);
        wait_drained();

        send_idle_pct  = 49;
        recv_stall_pct = 0;
        push_random_streams(50);
        wait_drained();

        send_idle_pct  = 0;
        recv_stall_pct = 49;
        push_random_streams(50);
        wait_drained();

        send_idle_pct  = 22;
        recv_stall_pct = 22;
        push_random_streams(50);
        push_item(ACT_END, 8'h00);
        wait_drained();

        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (err_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
